// ===== src/tcpu_pkg.sv =====
// Shared opcodes, status flag masks and types for the toy CPU execute unit.
// No dependencies.
package tcpu_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] reg_sel_t;

	localparam byte_t OP_NOP   = 8'd0;
	localparam byte_t OP_MOV_A = 8'd1;
	localparam byte_t OP_MOV_B = 8'd2;
	localparam byte_t OP_MOV_C = 8'd3;
	localparam byte_t OP_MOV_D = 8'd4;
	localparam byte_t OP_COPY  = 8'd5;
	localparam byte_t OP_STORE = 8'd6;
	localparam byte_t OP_LOAD  = 8'd7;
	localparam byte_t OP_ADD   = 8'd8;
	localparam byte_t OP_SUB   = 8'd9;
	localparam byte_t OP_INC   = 8'd10;
	localparam byte_t OP_DEC   = 8'd11;

	localparam byte_t FLAG_ZERO   = 8'h02;
	localparam byte_t FLAG_BORROW = 8'h04;
	localparam byte_t FLAG_CARRY  = 8'h10;
	localparam byte_t FLAG_WRAP   = 8'h12;
	localparam byte_t BYTE_MAX    = 8'hFF;

	localparam reg_sel_t REG_A = 2'd0;
	localparam reg_sel_t REG_B = 2'd1;
	localparam reg_sel_t REG_C = 2'd2;
	localparam reg_sel_t REG_D = 2'd3;

	typedef struct packed {
		byte_t       kind;
		byte_t       first_reg;
		byte_t       second_reg;
		byte_t       immediate;
		logic [15:0] mem_addr;
		byte_t       load_data;
	} instr_t;

endpackage

// ===== src/toy_cpu_execute_unit.sv =====
// Execute unit of a small 8-bit machine with four registers and a status byte.
// Depends on tcpu_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one decoded instruction per
//   beat: kind, first_reg, second_reg, immediate, mem_addr, load_data.
//   Output channel (out_valid / out_stall) returns one result beat for every
//   instruction: the store request, the status byte, the bad register mark
//   and registers A..D after the instruction.
//   The input register holds each beat, then the instruction executes
//   against registers A..D and the status byte and lands in the result
//   register. Throughput is one instruction per cycle while no result
//   is held by out_stall; the architectural registers update as the
//   result register loads, so the next instruction sees them. While
//   out_stall is high with a result waiting, the held instruction in
//   the input register stays put and in_stall rises; an empty input
//   register takes one more beat before the input side stalls.
//   Reset clears registers A..D, the status byte and both valid bits.
module toy_cpu_execute_unit
	import tcpu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  kind,
	input  logic [7:0]  first_reg,
	input  logic [7:0]  second_reg,
	input  logic [7:0]  immediate,
	input  logic [15:0] mem_addr,
	input  logic [7:0]  load_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        store_valid,
	output logic [15:0] store_addr,
	output logic [7:0]  store_data,
	output logic [7:0]  status_flags,
	output logic        bad_register,
	output logic [7:0]  a_value,
	output logic [7:0]  b_value,
	output logic [7:0]  c_value,
	output logic [7:0]  d_value
);

	logic   valid_s1;
	instr_t instr_s1;
	logic   advance;

	byte_t a_q, b_q, c_q, d_q, status_q;

	byte_t       a_nx, b_nx, c_nx, d_nx, status_nx;
	logic        st_valid_nx, bad_nx;
	logic [15:0] st_addr_nx;
	byte_t       st_data_nx;

	logic     r1_ok, r2_ok;
	reg_sel_t r1_sel, r2_sel;
	byte_t    src_val, dst_val, res_val;
	logic [8:0] sum_w;
	logic     wr_en;
	reg_sel_t wr_sel;

	function automatic byte_t pick_reg(reg_sel_t sel, byte_t a, byte_t b, byte_t c, byte_t d);
		byte_t v;
		unique case (sel)
			REG_A:   v = a;
			REG_B:   v = b;
			REG_C:   v = c;
			default: v = d;
		endcase
		return v;
	endfunction

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			instr_s1 <= '{kind, first_reg, second_reg, immediate, mem_addr, load_data};
		end
	end

	assign r1_sel  = instr_s1.first_reg[1:0];
	assign r2_sel  = instr_s1.second_reg[1:0];
	assign r1_ok   = (instr_s1.first_reg[7:2] == 6'd0);
	assign r2_ok   = (instr_s1.second_reg[7:2] == 6'd0);
	assign src_val = pick_reg(r1_sel, a_q, b_q, c_q, d_q);
	assign dst_val = pick_reg(r2_sel, a_q, b_q, c_q, d_q);
	assign sum_w   = {1'b0, src_val} + {1'b0, dst_val};

	always_comb begin
		status_nx   = status_q;
		st_valid_nx = 1'b0;
		st_addr_nx  = '0;
		st_data_nx  = '0;
		bad_nx      = 1'b0;
		wr_en       = 1'b0;
		wr_sel      = r1_sel;
		res_val     = src_val;
		unique case (instr_s1.kind) inside
			OP_MOV_A, OP_MOV_B, OP_MOV_C, OP_MOV_D: begin
				wr_en   = 1'b1;
				wr_sel  = reg_sel_t'(instr_s1.kind - OP_MOV_A);
				res_val = instr_s1.immediate;
				if (res_val == '0) status_nx = status_nx | FLAG_ZERO;
			end
			OP_COPY, OP_ADD, OP_SUB: begin
				if (!r1_ok || !r2_ok) begin
					bad_nx = 1'b1;
				end else begin
					wr_en  = 1'b1;
					wr_sel = r2_sel;
					if (instr_s1.kind == OP_ADD) begin
						res_val = sum_w[7:0];
						if (sum_w[8]) status_nx = status_nx | FLAG_CARRY;
					end else if (instr_s1.kind == OP_SUB) begin
						res_val = src_val - dst_val;
						if (src_val < dst_val) status_nx = status_nx | FLAG_BORROW;
					end
					if (res_val == '0) status_nx = status_nx | FLAG_ZERO;
				end
			end
			OP_STORE: begin
				if (!r1_ok) begin
					bad_nx = 1'b1;
				end else begin
					st_valid_nx = 1'b1;
					st_addr_nx  = instr_s1.mem_addr;
					st_data_nx  = src_val;
					if (src_val == '0) status_nx = status_nx | FLAG_ZERO;
				end
			end
			OP_LOAD: begin
				if (!r1_ok) begin
					bad_nx = 1'b1;
				end else begin
					wr_en   = 1'b1;
					res_val = instr_s1.load_data;
					if (res_val == '0) status_nx = status_nx | FLAG_ZERO;
				end
			end
			OP_INC: begin
				if (!r1_ok) begin
					bad_nx = 1'b1;
				end else begin
					wr_en   = 1'b1;
					res_val = src_val + 8'd1;
					if (src_val == BYTE_MAX) status_nx = status_nx | FLAG_WRAP;
				end
			end
			OP_DEC: begin
				if (!r1_ok) begin
					bad_nx = 1'b1;
				end else begin
					wr_en   = 1'b1;
					res_val = src_val + BYTE_MAX;
					if (src_val == '0) status_nx = status_nx | FLAG_CARRY;
					if (res_val == '0) status_nx = status_nx | FLAG_BORROW;
				end
			end
			default: begin
				// nop and unknown opcodes leave everything alone
			end
		endcase
	end

	assign a_nx = (wr_en && wr_sel == REG_A) ? res_val : a_q;
	assign b_nx = (wr_en && wr_sel == REG_B) ? res_val : b_q;
	assign c_nx = (wr_en && wr_sel == REG_C) ? res_val : c_q;
	assign d_nx = (wr_en && wr_sel == REG_D) ? res_val : d_q;

	// architectural state commits as the instruction retires into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q       <= '0;
			b_q       <= '0;
			c_q       <= '0;
			d_q       <= '0;
			status_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				a_q      <= a_nx;
				b_q      <= b_nx;
				c_q      <= c_nx;
				d_q      <= d_nx;
				status_q <= status_nx;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			store_valid  <= st_valid_nx;
			store_addr   <= st_addr_nx;
			store_data   <= st_data_nx;
			status_flags <= status_nx;
			bad_register <= bad_nx;
			a_value      <= a_nx;
			b_value      <= b_nx;
			c_value      <= c_nx;
			d_value      <= d_nx;
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for toy_cpu_execute_unit: directed table then random instructions,
// every result beat checked against a typed row or the in-bench model of A..D and status.
// Depends on tcpu_pkg and the execute unit RTL.
module testbench;
	import tcpu_pkg::*;

	typedef struct packed {
		logic        store_valid;
		logic [15:0] store_addr;
		byte_t       store_data;
		byte_t       status_flags;
		logic        bad_register;
		byte_t       a_value;
		byte_t       b_value;
		byte_t       c_value;
		byte_t       d_value;
	} exec_result_t;

	typedef struct packed {
		instr_t       ins;
		logic         typed;
		exec_result_t want;
	} directed_row_t;

	localparam int unsigned RANDOM_PER_PHASE = 288;
	localparam int unsigned CYCLE_LIMIT      = 200000;
	localparam int unsigned DRAIN_CYCLES     = 8;

	localparam byte_t CODE_A = {6'd0, REG_A};
	localparam byte_t CODE_B = {6'd0, REG_B};
	localparam byte_t CODE_C = {6'd0, REG_C};
	localparam byte_t CODE_D = {6'd0, REG_D};

	localparam exec_result_t CLEAN    = '0;
	localparam exec_result_t BAD_ONLY = '{bad_register: 1'b1, default: '0};

	// Rows up to the first untyped one start from reset state, so their results are known.
	localparam directed_row_t DIRECTED_ROWS [25] = '{
		'{'{OP_NOP,   8'h00,  8'h00,  8'h00, 16'h0000, 8'h00}, 1'b1, CLEAN},
		'{'{8'hFF,    8'hFF,  8'hFF,  8'hFF, 16'hFFFF, 8'hFF}, 1'b1, CLEAN},
		'{'{OP_STORE, 8'h04,  CODE_A, 8'h00, 16'hFFFF, 8'h00}, 1'b1, BAD_ONLY},
		'{'{OP_LOAD,  8'hFF,  CODE_A, 8'h00, 16'h0000, 8'hFF}, 1'b1, BAD_ONLY},
		'{'{OP_INC,   8'h80,  CODE_A, 8'h00, 16'h0000, 8'h00}, 1'b1, BAD_ONLY},
		'{'{OP_DEC,   8'h04,  CODE_A, 8'h00, 16'h0000, 8'h00}, 1'b1, BAD_ONLY},
		'{'{OP_COPY,  CODE_A, 8'h04,  8'h00, 16'h0000, 8'h00}, 1'b1, BAD_ONLY},
		'{'{OP_ADD,   8'hFF,  CODE_A, 8'h00, 16'h0000, 8'h00}, 1'b1, BAD_ONLY},
		'{'{OP_SUB,   CODE_A, 8'hFF,  8'h00, 16'h0000, 8'h00}, 1'b1, BAD_ONLY},
		// unused register fields are ignored
		'{'{OP_MOV_A, 8'hFF,  8'hFF,  8'hFF, 16'h0000, 8'h00}, 1'b1,
			'{1'b0, 16'h0000, 8'h00, 8'h00, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00}},
		'{'{OP_MOV_B, 8'hFF,  8'h00,  8'h00, 16'h0000, 8'h00}, 1'b1,
			'{1'b0, 16'h0000, 8'h00, FLAG_ZERO, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00}},
		'{'{OP_INC,   CODE_A, 8'hFF,  8'h00, 16'h0000, 8'h00}, 1'b1,
			'{1'b0, 16'h0000, 8'h00, FLAG_WRAP, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00}},
		'{'{OP_DEC,   CODE_B, 8'hFF,  8'h00, 16'h0000, 8'h00}, 1'b1,
			'{1'b0, 16'h0000, 8'h00, FLAG_WRAP, 1'b0, 8'h00, 8'hFF, 8'h00, 8'h00}},
		'{'{OP_MOV_C, 8'h00,  8'h00,  8'h01, 16'h0000, 8'h00}, 1'b0, CLEAN},
		'{'{OP_SUB,   CODE_C, CODE_B, 8'h00, 16'h0000, 8'h00}, 1'b0, CLEAN},
		'{'{OP_MOV_D, 8'h00,  8'h00,  8'h80, 16'h0000, 8'h00}, 1'b0, CLEAN},
		'{'{OP_ADD,   CODE_D, CODE_D, 8'h00, 16'h0000, 8'h00}, 1'b0, CLEAN},
		'{'{OP_COPY,  CODE_B, CODE_C, 8'h00, 16'h0000, 8'h00}, 1'b0, CLEAN},
		'{'{OP_STORE, CODE_B, 8'hFF,  8'h00, 16'hFFFF, 8'h00}, 1'b0, CLEAN},
		'{'{OP_STORE, CODE_D, 8'h00,  8'h00, 16'h0000, 8'h00}, 1'b0, CLEAN},
		'{'{OP_LOAD,  CODE_C, 8'h00,  8'h00, 16'h8001, 8'h00}, 1'b0, CLEAN},
		'{'{OP_LOAD,  CODE_A, 8'h00,  8'h00, 16'h7FFE, 8'hFF}, 1'b0, CLEAN},
		'{'{OP_MOV_A, 8'h00,  8'h00,  8'h01, 16'h0000, 8'h00}, 1'b0, CLEAN},
		'{'{OP_DEC,   CODE_A, 8'h00,  8'h00, 16'h0000, 8'h00}, 1'b0, CLEAN},
		'{'{OP_INC,   CODE_D, 8'h00,  8'h00, 16'h0000, 8'h00}, 1'b0, CLEAN}
	};

	localparam int unsigned IDLE_PCT  [4] = '{0, 48, 0, 23};
	localparam int unsigned STALL_PCT [4] = '{0, 0, 48, 23};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  kind;
	logic [7:0]  first_reg;
	logic [7:0]  second_reg;
	logic [7:0]  immediate;
	logic [15:0] mem_addr;
	logic [7:0]  load_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        store_valid;
	logic [15:0] store_addr;
	logic [7:0]  store_data;
	logic [7:0]  status_flags;
	logic        bad_register;
	logic [7:0]  a_value;
	logic [7:0]  b_value;
	logic [7:0]  c_value;
	logic [7:0]  d_value;

	byte_t          gpr_q [4];
	byte_t          flags_q;
	exec_result_t   pending_results [$];
	int unsigned    idle_pct;
	int unsigned    stall_pct;
	int unsigned    mismatches;
	int unsigned    result_beats;
	int unsigned    cycles;

	toy_cpu_execute_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.first_reg    (first_reg),
		.second_reg   (second_reg),
		.immediate    (immediate),
		.mem_addr     (mem_addr),
		.load_data    (load_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.store_valid  (store_valid),
		.store_addr   (store_addr),
		.store_data   (store_data),
		.status_flags (status_flags),
		.bad_register (bad_register),
		.a_value      (a_value),
		.b_value      (b_value),
		.c_value      (c_value),
		.d_value      (d_value)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit code_ok(input byte_t code);
		return code[7:2] == 6'd0;
	endfunction

	function automatic void mark_zero(input byte_t value);
		if (value == 8'h00)
			flags_q = flags_q | FLAG_ZERO;
	endfunction

	// Execute one instruction against the model registers and return the result beat.
	function automatic exec_result_t execute_instr(input instr_t ins);
		exec_result_t r;
		reg_sel_t     src_sel;
		reg_sel_t     dst_sel;
		byte_t        src;
		byte_t        dst;
		logic [8:0]   sum;
		r = '0;
		src_sel = reg_sel_t'(ins.first_reg[1:0]);
		dst_sel = reg_sel_t'(ins.second_reg[1:0]);
		case (ins.kind)
		OP_MOV_A, OP_MOV_B, OP_MOV_C, OP_MOV_D: begin
			gpr_q[reg_sel_t'(ins.kind - OP_MOV_A)] = ins.immediate;
			mark_zero(ins.immediate);
		end
		OP_COPY, OP_ADD, OP_SUB: begin
			if (!code_ok(ins.first_reg) || !code_ok(ins.second_reg)) begin
				r.bad_register = 1'b1;
			end else begin
				src = gpr_q[src_sel];
				dst = gpr_q[dst_sel];
				if (ins.kind == OP_COPY) begin
					dst = src;
				end else if (ins.kind == OP_ADD) begin
					sum = {1'b0, src} + {1'b0, dst};
					if (sum[8])
						flags_q = flags_q | FLAG_CARRY;
					dst = sum[7:0];
				end else begin
					if (src < dst)
						flags_q = flags_q | FLAG_BORROW;
					dst = src - dst;
				end
				gpr_q[dst_sel] = dst;
				mark_zero(dst);
			end
		end
		OP_STORE: begin
			if (!code_ok(ins.first_reg)) begin
				r.bad_register = 1'b1;
			end else begin
				r.store_valid = 1'b1;
				r.store_addr = ins.mem_addr;
				r.store_data = gpr_q[src_sel];
				mark_zero(gpr_q[src_sel]);
			end
		end
		OP_LOAD: begin
			if (!code_ok(ins.first_reg)) begin
				r.bad_register = 1'b1;
			end else begin
				gpr_q[src_sel] = ins.load_data;
				mark_zero(ins.load_data);
			end
		end
		OP_INC: begin
			if (!code_ok(ins.first_reg)) begin
				r.bad_register = 1'b1;
			end else begin
				if (gpr_q[src_sel] == BYTE_MAX)
					flags_q = flags_q | FLAG_WRAP;
				gpr_q[src_sel] = gpr_q[src_sel] + 8'd1;
			end
		end
		OP_DEC: begin
			if (!code_ok(ins.first_reg)) begin
				r.bad_register = 1'b1;
			end else begin
				if (gpr_q[src_sel] == 8'h00)
					flags_q = flags_q | FLAG_CARRY;
				gpr_q[src_sel] = gpr_q[src_sel] - 8'd1;
				if (gpr_q[src_sel] == 8'h00)
					flags_q = flags_q | FLAG_BORROW;
			end
		end
		default: begin
		end
		endcase
		r.status_flags = flags_q;
		r.a_value = gpr_q[REG_A];
		r.b_value = gpr_q[REG_B];
		r.c_value = gpr_q[REG_C];
		r.d_value = gpr_q[REG_D];
		return r;
	endfunction

	function automatic byte_t random_byte();
		case ($urandom_range(7))
		0: return 8'h00;
		1: return BYTE_MAX;
		default: return byte_t'($urandom_range(255));
		endcase
	endfunction

	function automatic byte_t random_reg_code();
		if ($urandom_range(99) < 92)
			return {6'd0, reg_sel_t'($urandom_range(3))};
		return byte_t'($urandom_range(255));
	endfunction

	function automatic instr_t random_instr();
		instr_t ins;
		if ($urandom_range(99) < 88)
			ins.kind = byte_t'($urandom_range(OP_DEC));
		else
			ins.kind = byte_t'($urandom_range(255));
		ins.first_reg = random_reg_code();
		ins.second_reg = random_reg_code();
		ins.immediate = random_byte();
		ins.mem_addr = 16'($urandom);
		ins.load_data = random_byte();
		return ins;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d, result beat %0d: %s", cycles, result_beats, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
		input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// Present one instruction beat, hold it until taken, then log its expected result.
	task automatic send_instr(input instr_t ins, input bit typed, input exec_result_t want);
		exec_result_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind = ins.kind;
		first_reg = ins.first_reg;
		second_reg = ins.second_reg;
		immediate = ins.immediate;
		mem_addr = ins.mem_addr;
		load_data = ins.load_data;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = execute_instr(ins);
		pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n)
			out_stall = 1'b0;
		else
			out_stall = ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		exec_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = pending_results.pop_front();
				check_field("store_valid", store_valid, want.store_valid);
				check_field("store_addr", store_addr, want.store_addr);
				check_field("store_data", store_data, want.store_data);
				check_field("status_flags", status_flags, want.status_flags);
				check_field("bad_register", bad_register, want.bad_register);
				check_field("a_value", a_value, want.a_value);
				check_field("b_value", b_value, want.b_value);
				check_field("c_value", c_value, want.c_value);
				check_field("d_value", d_value, want.d_value);
			end
			result_beats++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		first_reg = '0;
		second_reg = '0;
		immediate = '0;
		mem_addr = '0;
		load_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		result_beats = 0;
		cycles = 0;
		flags_q = '0;
		foreach (gpr_q[i])
			gpr_q[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (DIRECTED_ROWS[i])
			send_instr(DIRECTED_ROWS[i].ins, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = IDLE_PCT[phase];
			stall_pct = STALL_PCT[phase];
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_instr(random_instr(), 1'b0, CLEAN);
				// hold off once mid-phase until the pipe is empty
				if (n == RANDOM_PER_PHASE / 2)
					wait_drained();
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
